### rtl/fir_fc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and control structs for the full-convolution FIR filter.
package fir_fc_pkg;

  localparam int TAPS      = 16;
  localparam int TAP_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W     = $clog2(TAPS + 1);
  localparam int SAMPLE_W  = 16;
  localparam int COEFF_W   = 16;
  localparam int IDX_W     = 4;
  localparam int TCNT_W    = 5;
  localparam int PROD_W    = SAMPLE_W + COEFF_W + 1;
  localparam int ACC_W     = 36;

  localparam logic [COEFF_W-1:0] COEFF_ONE       = COEFF_W'(32768);
  localparam logic [TCNT_W-1:0]  TAP_COUNT_RESET = TCNT_W'(16);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic dly_ok;
  } mac_ctl_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] sum;
  } mac_stat_t;

endpackage

### rtl/fir_fc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and results.
interface fir_fc_in_if
  import fir_fc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [IDX_W-1:0]           coeff_index;
  logic [COEFF_W-1:0]         coeff_value;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, opcode, coeff_index, coeff_value, sample, last_sample,
                  input ready);
  modport sink   (input valid, opcode, coeff_index, coeff_value, sample, last_sample,
                  output ready);
endinterface

interface fir_fc_out_if
  import fir_fc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] filtered_value;
  logic                    last_result;

  modport source (output valid, filtered_value, last_result, input ready);
  modport sink   (input valid, filtered_value, last_result, output ready);
endinterface

### rtl/fir_fc_top.sv
`timescale 1ns / 1ps
// Full-convolution FIR filter top level.
//
// item channel: opcode 0 loads coefficient coeff_index (saturated to 1.0 = 32768),
// opcode 1 presents a Q1.15 sample; last_sample on a sample ends the block.
// result channel: one 36-bit Q.30 sum per sample, plus tap_count-1 tail sums after
// the last sample of a block; last_result flags the final sum of the block.
// cfg_we/cfg_wdata write tap_count (0 acts as 1, values above 16 act as 16);
// write only while the filter is idle.
// Sequencing: a sample is written in the transfer cycle, then one shared
// multiply-accumulate steps one tap per cycle through the coefficient and delay-line
// RAM read ports; each sum passes the RAM data stage, product register and
// accumulator before it reaches the result register. A new sample is taken only
// after the sums of the one before are done. item.ready is high only between items.
// A stalled receiver holds the result register; the filter finishes the next sum
// and then waits until the held result is taken.
// Reset (rst, synchronous) clears the delay line, sets tap_count to 16 and empties
// the result register; coefficients are undefined until loaded.
module fir_full_convolution_top
  import fir_fc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TCNT_W-1:0] cfg_wdata,
  fir_fc_in_if.sink         item,
  fir_fc_out_if.source      result
);

  mac_ctl_t            ctl;
  mac_stat_t           stat;
  logic                coef_we, dly_we;
  logic [TAP_W-1:0]    coef_waddr, coef_raddr, dly_waddr, dly_raddr;
  logic [COEFF_W-1:0]  coef_wdata, coef_rd;
  logic [SAMPLE_W-1:0] dly_wdata, dly_rd;

  fir_fc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .result     (result),
    .stat       (stat),
    .ctl        (ctl),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .dly_we     (dly_we),
    .dly_waddr  (dly_waddr),
    .dly_wdata  (dly_wdata),
    .dly_raddr  (dly_raddr)
  );

  fir_fc_ram #(.WIDTH(COEFF_W), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  fir_fc_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .raddr (dly_raddr),
    .rdata (dly_rd)
  );

  fir_fc_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .coef_rd (coef_rd),
    .dly_rd  (dly_rd),
    .stat    (stat)
  );

endmodule

### rtl/fir_fc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fir_fc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fir_fc_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate pipeline: RAM data stage, product register, accumulator.
module fir_fc_mac
  import fir_fc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mac_ctl_t            ctl,
  input  logic [COEFF_W-1:0]  coef_rd,
  input  logic [SAMPLE_W-1:0] dly_rd,
  output mac_stat_t           stat
);

  logic                     s1_vld, s1_first, s1_last, s1_ok;
  logic                     p_vld, p_first, p_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [SAMPLE_W-1:0] operand;
  logic signed [ACC_W-1:0]  acc;
  logic                     done;

  assign operand = s1_ok ? $signed(dly_rd) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      p_vld  <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= ctl.issue;
      p_vld  <= s1_vld;
      done   <= p_vld && p_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= ctl.first;
    s1_last  <= ctl.last;
    s1_ok    <= ctl.dly_ok;
    p_first  <= s1_first;
    p_last   <= s1_last;
    prod     <= $signed({1'b0, coef_rd}) * operand;
    if (p_vld) begin
      acc <= p_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign stat.done = done;
  assign stat.sum  = acc;

endmodule

### rtl/fir_fc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: tap count register, delay-line pointers and valid bits, result register.
module fir_fc_ctrl
  import fir_fc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [TCNT_W-1:0]   cfg_wdata,
  fir_fc_in_if.sink           item,
  fir_fc_out_if.source        result,
  input  mac_stat_t           stat,
  output mac_ctl_t            ctl,
  output logic                coef_we,
  output logic [TAP_W-1:0]    coef_waddr,
  output logic [COEFF_W-1:0]  coef_wdata,
  output logic [TAP_W-1:0]    coef_raddr,
  output logic                dly_we,
  output logic [TAP_W-1:0]    dly_waddr,
  output logic [SAMPLE_W-1:0] dly_wdata,
  output logic [TAP_W-1:0]    dly_raddr
);

  state_t                  state, state_next;
  logic [TCNT_W-1:0]       tap_count;
  logic [TAP_W-1:0]        head, rptr, head_inc, rptr_dec;
  logic [CNT_W-1:0]        k, taps_q, flush, active;
  logic                    last_q;
  logic [TAPS-1:0]         dvalid;
  logic                    out_valid;
  logic signed [ACC_W-1:0] out_value;
  logic                    out_last;
  logic                    xfer, take_sample, emit_go, more;

  assign head_inc = (head == TAP_W'(TAPS - 1)) ? '0 : head + 1'b1;
  assign rptr_dec = (rptr == '0) ? TAP_W'(TAPS - 1) : rptr - 1'b1;

  always_comb begin
    if (tap_count == '0) begin
      active = CNT_W'(1);
    end else if (32'(tap_count) > TAPS) begin
      active = CNT_W'(TAPS);
    end else begin
      active = CNT_W'(tap_count);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_sample) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (ctl.last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_next = more ? ST_MAC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready  = (state == ST_IDLE);
    xfer        = item.valid && item.ready;
    take_sample = xfer && (item.opcode == OP_SAMPLE);
    coef_we     = xfer && (item.opcode == OP_LOAD) && (32'(item.coeff_index) < TAPS);
    coef_waddr  = TAP_W'(item.coeff_index);
    coef_wdata  = (item.coeff_value > COEFF_ONE) ? COEFF_ONE : item.coeff_value;
    coef_raddr  = k[TAP_W-1:0];
    dly_we      = take_sample;
    dly_waddr   = head_inc;
    dly_wdata   = item.sample;
    dly_raddr   = rptr;
    ctl.issue   = (state == ST_MAC);
    ctl.first   = (k == '0);
    ctl.last    = (state == ST_MAC) && (k == taps_q - 1'b1);
    ctl.dly_ok  = dvalid[rptr];
    emit_go     = (state == ST_EMIT) && (!out_valid || result.ready);
    more        = last_q && (flush != taps_q - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TAP_COUNT_RESET;
      head      <= '0;
      dvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tap_count <= cfg_wdata;
      end
      if (take_sample) begin
        head             <= head_inc;
        dvalid[head_inc] <= 1'b1;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_go && more) begin
        head             <= head_inc;
        dvalid[head_inc] <= 1'b0;
      end else if (emit_go && last_q) begin
        dvalid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      rptr   <= head_inc;
      k      <= '0;
      flush  <= '0;
      taps_q <= active;
      last_q <= item.last_sample;
    end else if (state == ST_MAC) begin
      rptr <= rptr_dec;
      k    <= k + 1'b1;
    end else if (emit_go && more) begin
      rptr  <= head_inc;
      k     <= '0;
      flush <= flush + 1'b1;
    end
    if (emit_go) begin
      out_value <= stat.sum;
      out_last  <= last_q && (flush == taps_q - 1'b1);
    end
  end

  assign result.valid          = out_valid;
  assign result.filtered_value = out_value;
  assign result.last_result    = out_last;

endmodule

### verif/tb_fir_full_convolution_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the full-convolution FIR filter top level.
module tb_fir_full_convolution_top;
  import fir_fc_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int LOAD_SETTLE  = 30;
  localparam int END_SETTLE   = 40;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 34;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } fir_sum_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TCNT_W-1:0] cfg_wdata;

  fir_fc_in_if  item_if ();
  fir_fc_out_if res_if ();

  fir_full_convolution_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (res_if)
  );

  // filter model state
  logic [TCNT_W-1:0]          tap_count_q;
  logic [COEFF_W-1:0]         coeff_mem [TAPS];
  logic signed [SAMPLE_W-1:0] delay_mem [TAPS];
  fir_sum_t                   pending_sums [$];

  int unsigned err_cnt;
  int unsigned load_cnt;
  int unsigned sample_cnt;
  int unsigned result_cnt;
  int unsigned cfg_cnt;
  int unsigned quiet_cycles;
  int          burst_left;
  int          hold_request;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic void shift_delay(input logic signed [SAMPLE_W-1:0] v);
    for (int i = TAPS - 1; i > 0; i--) delay_mem[i] = delay_mem[i - 1];
    delay_mem[0] = v;
  endfunction

  function automatic logic signed [ACC_W-1:0] tap_sum(input int taps);
    longint acc;
    acc = 0;
    for (int k = 0; k < taps; k++) acc += longint'(coeff_mem[k]) * longint'(delay_mem[k]);
    return acc[ACC_W-1:0];
  endfunction

  // one sum per sample, plus the tail flush after the last sample of a block
  function automatic void convolve_sample(input logic signed [SAMPLE_W-1:0] smp,
                                          input logic lst);
    int       taps;
    fir_sum_t r;
    taps = (tap_count_q == 0) ? 1 : (tap_count_q > TAPS) ? TAPS : int'(tap_count_q);
    shift_delay(smp);
    r.value = tap_sum(taps);
    r.last  = lst && (taps == 1);
    pending_sums.push_back(r);
    if (lst) begin
      for (int t = 1; t < taps; t++) begin
        shift_delay('0);
        r.value = tap_sum(taps);
        r.last  = (t == taps - 1);
        pending_sums.push_back(r);
      end
      for (int i = 0; i < TAPS; i++) delay_mem[i] = '0;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return COEFF_ONE;
      1: return COEFF_W'($urandom_range(32769, 65535));
      2: return '0;
      default: return COEFF_W'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [COEFF_W-1:0] cval,
                           input logic signed [SAMPLE_W-1:0] smp, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        item_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    item_if.valid       <= 1'b1;
    item_if.opcode      <= op;
    item_if.coeff_index <= idx;
    item_if.coeff_value <= cval;
    item_if.sample      <= smp;
    item_if.last_sample <= lst;
    do @(posedge clk); while (!item_if.ready);
    if (op == OP_LOAD) begin
      if (idx < TAPS) coeff_mem[idx] = (cval > COEFF_ONE) ? COEFF_ONE : cval;
      load_cnt++;
    end else begin
      convolve_sample(smp, lst);
      sample_cnt++;
    end
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [TCNT_W-1:0] v);
    drain(LOAD_SETTLE);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tap_count_q = v;
    cfg_cnt++;
  endtask

  task automatic test_coeff_load();
    for (int i = 0; i < TAPS; i++) begin
      case (i)
        0: send_item(OP_LOAD, IDX_W'(i), COEFF_ONE, '0, 1'b0);
        1: send_item(OP_LOAD, IDX_W'(i), 16'hffff, 16'sh7fff, 1'b0);
        2: send_item(OP_LOAD, IDX_W'(i), 16'd32769, '0, 1'b0);
        3: send_item(OP_LOAD, IDX_W'(i), 16'h0000, 16'sh8000, 1'b0);
        15: send_item(OP_LOAD, IDX_W'(i), 16'h5555, '0, 1'b1);
        default: send_item(OP_LOAD, IDX_W'(i), COEFF_W'($urandom_range(0, 32768)), '0, 1'b0);
      endcase
    end
  endtask

  task automatic test_sample_extremes();
    send_item(OP_SAMPLE, '0, '0, 16'sh7fff, 1'b0);
    send_item(OP_SAMPLE, '1, '1, 16'sh8000, 1'b0);
    send_item(OP_SAMPLE, '0, '0, -16'sd1, 1'b0);
    send_item(OP_SAMPLE, '0, '0, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, '0, '0, 16'sd1, 1'b1);
  endtask

  // zero acts as one tap, anything above 16 acts as 16
  task automatic test_tap_count_limits();
    write_tap_count('0);
    send_item(OP_SAMPLE, '0, '0, 16'sh8000, 1'b1);
    write_tap_count('1);
    send_item(OP_SAMPLE, '0, '0, 16'sh7fff, 1'b1);
    write_tap_count(TCNT_W'(1));
    send_item(OP_SAMPLE, '0, '0, 16'sd1, 1'b0);
    send_item(OP_SAMPLE, '0, '0, 16'sh7fff, 1'b1);
  endtask

  task automatic test_mid_block_change();
    write_tap_count(TCNT_W'(4));
    send_item(OP_SAMPLE, '0, '0, 16'sd100, 1'b0);
    send_item(OP_SAMPLE, '0, '0, -16'sd200, 1'b0);
    write_tap_count(TCNT_W'(9));
    send_item(OP_LOAD, IDX_W'(2), 16'd40000, '0, 1'b1);
    send_item(OP_SAMPLE, '0, '0, 16'sd300, 1'b0);
    send_item(OP_SAMPLE, '0, '0, 16'sh8000, 1'b1);
  endtask

  // result side stalls long enough for the filter to back up into the item side
  task automatic test_backpressure();
    write_tap_count(TAP_COUNT_RESET);
    hold_request = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_item(OP_SAMPLE, '0, '0, rand_sample(), i == 11);
    drain(END_SETTLE);
  endtask

  task automatic test_random_blocks();
    logic [TCNT_W-1:0] tc;
    int                phase_items;
    int                blk_len;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: tc = TAP_COUNT_RESET;
        1: tc = TCNT_W'(1);
        2: tc = '0;
        3: tc = '1;
        4: tc = TCNT_W'($urandom_range(17, 30));
        default: tc = TCNT_W'($urandom_range(2, 15));
      endcase
      write_tap_count(tc);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        blk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0) hold_request = $urandom_range(50, 300);
        for (int i = 0; i < blk_len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(OP_LOAD, IDX_W'($urandom_range(0, 15)), rand_coeff(),
                      SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
            phase_items++;
          end
          // an occasional block runs on without its last-sample mark
          send_item(OP_SAMPLE, IDX_W'($urandom), COEFF_W'($urandom), rand_sample(),
                    (i == blk_len - 1) && ($urandom_range(0, 11) != 0));
          phase_items++;
        end
      end
    end
  endtask

  // result receiver: random stall patterns, plus long holds on request
  initial begin : result_sink
    int hold_left;
    int pat_mode;
    int pat_left;
    hold_left = 0;
    pat_mode  = 0;
    pat_left  = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        case (pat_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (pat_left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    fir_sum_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      result_cnt++;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected", res_if.filtered_value));
      end else begin
        want = pending_sums.pop_front();
        if (res_if.filtered_value !== want.value)
          report_mismatch($sformatf("filtered_value got %0d exp %0d",
                                    res_if.filtered_value, want.value));
        if (res_if.last_result !== want.last)
          report_mismatch($sformatf("last_result got %b exp %b",
                                    res_if.last_result, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    item_if.valid       = 1'b0;
    item_if.opcode      = OP_LOAD;
    item_if.coeff_index = '0;
    item_if.coeff_value = '0;
    item_if.sample      = '0;
    item_if.last_sample = 1'b0;
    tap_count_q         = TAP_COUNT_RESET;
    for (int i = 0; i < TAPS; i++) begin
      coeff_mem[i] = '0;
      delay_mem[i] = '0;
    end
    err_cnt      = 0;
    load_cnt     = 0;
    sample_cnt   = 0;
    result_cnt   = 0;
    cfg_cnt      = 0;
    burst_left   = 0;
    hold_request = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_coeff_load();
    test_sample_extremes();
    test_tap_count_limits();
    test_mid_block_change();
    test_backpressure();
    test_random_blocks();
    drain(END_SETTLE);

    if (pending_sums.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_sums.size()));
    $display("Covered %0d coefficient loads and %0d samples over %0d tap-count writes,",
             load_cnt, sample_cnt, cfg_cnt);
    $display("including limit tap counts, saturation and back-pressure; %0d results checked",
             result_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
